### design/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// types, codes and sizes shared by the deadline timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SEQ_BITS  = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int TIME_W    = 63;
  localparam int IV_W      = 32;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_CANCEL = 2'd1,
    FN_TICK   = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_CRD,
    S_CCHK,
    S_DONE,
    S_ESCAN,
    S_EMIT
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [TIME_W-1:0]  deadline;
    logic [IV_W-1:0]    repeat_interval;
    logic [TIME_W-1:0]  tick_time;
    logic [3:0]         cancel_slot;
    logic [15:0]        cancel_seq;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [3:0]         handle_slot;
    logic [15:0]        handle_seq;
    logic               fired;
    logic               last;
    logic               earliest_changed;
    logic               next_valid;
    logic [TIME_W-1:0]  next_deadline;
  } res_t;

  typedef struct packed {
    logic [TIME_W-1:0]   deadline;
    logic [IV_W-1:0]     interval;
    logic [SEQ_BITS-1:0] seq;
  } entry_t;

  // re-arm time, saturating at the top of the time range
  function automatic logic [TIME_W-1:0] rearm(input logic [TIME_W-1:0] now,
                                              input logic [IV_W-1:0] iv);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + {{(TIME_W + 1 - IV_W){1'b0}}, iv};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

### design/dtq_slot_ram.sv
// ----------------------------------------------------------------------------
// dtq_slot_ram
// single-port slot store, registered read data
// ----------------------------------------------------------------------------
module dtq_slot_ram import dtq_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] addr_i,
  input  entry_t            wdata_i,
  output entry_t            rdata_o
);

  entry_t mem [NUM_SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

### design/deadline_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// timer slot table searched by deadline: add, cancel and time tick
// ----------------------------------------------------------------------------
//  channel   | ports                          | transaction
//  ----------+--------------------------------+------------------------------
//  request   | start_i, busy_o, req_i         | start_i high while busy_o low
//  result    | res_valid_o, res_o             | res_valid_o high, one cycle
//
//  add makes one sweep of the slot memory; cancel reads the named slot, then makes one sweep
//  tick makes one sweep when nothing expires, else one more sweep per fired timer:
//  a first sweep finds the next deadline and the expired slots, then one sweep
//  per timer picks the earliest
//  all cost comes from the single port of the slot memory, one entry a cycle
//  reset clears valid bits and the sequence counter; the memory is not reset
//  results cannot be stalled; busy_o falls in the cycle of the last result
module deadline_timer_queue_unit import dtq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  req_t                 in_q, in_d;
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  logic                 min_vld_q, min_vld_d;
  logic [TIME_W-1:0]    min_q, min_d;
  logic                 best_vld_q, best_vld_d;
  logic [SLOT_W-1:0]    best_slot_q, best_slot_d;
  entry_t               best_q, best_d;
  logic [SEQ_BITS-1:0]  seq_cnt_q, seq_cnt_d;
  logic                 can_ok_q, can_ok_d;
  res_t                 res_q, res_d;
  logic                 res_vld_q, res_vld_d;

  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_addr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;

  logic [SLOT_W-1:0]    idx;
  logic [SLOT_W-1:0]    free_slot;
  logic                 full;
  logic                 expired;
  logic                 cand;
  logic [TIME_W-1:0]    value;
  logic                 changed;

  dtq_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign idx  = SLOT_W'(cnt_q - CNT_W'(1));
  assign full = &valid_q;

  always_comb begin
    free_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      valid_q    <= '0;
      pend_q     <= '0;
      min_vld_q  <= 1'b0;
      best_vld_q <= 1'b0;
      seq_cnt_q  <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      valid_q    <= valid_d;
      pend_q     <= pend_d;
      min_vld_q  <= min_vld_d;
      best_vld_q <= best_vld_d;
      seq_cnt_q  <= seq_cnt_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    min_q       <= min_d;
    best_slot_q <= best_slot_d;
    best_q      <= best_d;
    can_ok_q    <= can_ok_d;
    res_q       <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_d        = in_q;
    valid_d     = valid_q;
    pend_d      = pend_q;
    min_vld_d   = min_vld_q;
    min_d       = min_q;
    best_vld_d  = best_vld_q;
    best_slot_d = best_slot_q;
    best_d      = best_q;
    seq_cnt_d   = seq_cnt_q;
    can_ok_d    = can_ok_q;
    res_d       = res_q;
    res_vld_d   = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = cnt_q[SLOT_W-1:0];
    ram_wdata   = best_q;
    expired     = valid_q[idx] && (ram_rdata.deadline <= in_q.tick_time);
    cand        = 1'b0;
    value       = ram_rdata.deadline;
    changed     = !min_vld_q || (in_q.deadline < min_q);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          in_d      = req_i;
          cnt_d     = '0;
          min_vld_d = 1'b0;
          pend_d    = '0;
          case (req_i.func)
            FN_ADD, FN_TICK: state_d = S_SCAN;
            FN_CANCEL:       state_d = S_CRD;
            default:         state_d = S_IDLE;
          endcase
        end
      end
      S_CRD: begin
        ram_addr = SLOT_W'(in_q.cancel_slot);
        state_d  = S_CCHK;
      end
      S_CCHK: begin
        can_ok_d = valid_q[SLOT_W'(in_q.cancel_slot)] &&
                   (16'(ram_rdata.seq) == in_q.cancel_seq);
        if (can_ok_d) begin
          valid_d[SLOT_W'(in_q.cancel_slot)] = 1'b0;
        end
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_q != '0) begin
          if (in_q.func == FN_TICK) begin
            pend_d[idx] = expired;
            cand  = valid_q[idx] && !(expired && (ram_rdata.interval == '0));
            value = expired ? rearm(in_q.tick_time, ram_rdata.interval)
                            : ram_rdata.deadline;
          end else begin
            cand = valid_q[idx];
          end
          if (cand && (!min_vld_q || (value < min_q))) begin
            min_vld_d = 1'b1;
            min_d     = value;
          end
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_SLOTS)) begin
          cnt_d      = '0;
          best_vld_d = 1'b0;
          case (in_q.func)
            FN_ADD:  state_d = S_ADD;
            FN_TICK: state_d = (pend_d != '0) ? S_ESCAN : S_DONE;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ADD: begin
        res_vld_d              = 1'b1;
        res_d.fired            = 1'b0;
        res_d.last             = 1'b1;
        res_d.next_valid       = min_vld_q;
        res_d.next_deadline    = min_vld_q ? min_q : '0;
        res_d.status           = STAT_FULL;
        res_d.handle_slot      = '0;
        res_d.handle_seq       = '0;
        res_d.earliest_changed = 1'b0;
        if (!full) begin
          ram_we             = 1'b1;
          ram_addr           = free_slot;
          ram_wdata.deadline = in_q.deadline;
          ram_wdata.interval = in_q.repeat_interval;
          ram_wdata.seq      = seq_cnt_q;
          valid_d[free_slot] = 1'b1;
          seq_cnt_d          = seq_cnt_q + SEQ_BITS'(1);
          res_d.status           = STAT_OK;
          res_d.handle_slot      = 4'(free_slot);
          res_d.handle_seq       = 16'(seq_cnt_q);
          res_d.earliest_changed = changed;
          res_d.next_valid       = 1'b1;
          res_d.next_deadline    = changed ? in_q.deadline : min_q;
        end
        state_d = S_IDLE;
      end
      S_DONE: begin
        res_vld_d              = 1'b1;
        res_d.status           = (in_q.func == FN_TICK) ? STAT_EMPTY :
                                 (can_ok_q ? STAT_OK : STAT_NOTFOUND);
        res_d.handle_slot      = '0;
        res_d.handle_seq       = '0;
        res_d.fired            = 1'b0;
        res_d.last             = 1'b1;
        res_d.earliest_changed = 1'b0;
        res_d.next_valid       = min_vld_q;
        res_d.next_deadline    = min_vld_q ? min_q : '0;
        state_d                = S_IDLE;
      end
      S_ESCAN: begin
        if ((cnt_q != '0) && pend_q[idx] &&
            (!best_vld_q || (ram_rdata.deadline < best_q.deadline))) begin
          best_vld_d  = 1'b1;
          best_slot_d = idx;
          best_d      = ram_rdata;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_SLOTS)) begin
          cnt_d   = '0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        ram_we             = 1'b1;
        ram_addr           = best_slot_q;
        ram_wdata.deadline = rearm(in_q.tick_time, best_q.interval);
        if (best_q.interval == '0) begin
          valid_d[best_slot_q] = 1'b0;
        end
        pend_d[best_slot_q]    = 1'b0;
        best_vld_d             = 1'b0;
        res_vld_d              = 1'b1;
        res_d.status           = STAT_OK;
        res_d.handle_slot      = 4'(best_slot_q);
        res_d.handle_seq       = 16'(best_q.seq);
        res_d.fired            = 1'b1;
        res_d.last             = (pend_d == '0);
        res_d.earliest_changed = 1'b0;
        res_d.next_valid       = min_vld_q;
        res_d.next_deadline    = min_vld_q ? min_q : '0;
        state_d                = (pend_d == '0) ? S_IDLE : S_ESCAN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

### design/dtq_checker.sv
// ----------------------------------------------------------------------------
// dtq_checker
// port-level checks of the deadline timer queue
// ----------------------------------------------------------------------------
module dtq_checker import dtq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic res_valid_o,
  input res_t res_o
);

  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.fired |-> res_o.status == STAT_OK)
    else $error("fired result without ok status");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.next_valid |-> res_o.next_deadline == '0)
    else $error("next deadline set with no armed timer");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == STAT_EMPTY || res_o.status == STAT_FULL)
    |-> res_o.last && !res_o.fired)
    else $error("single-result transaction not marked last");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.func != FN_NONE |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy_o)
    else $error("idle before final result");

endmodule

bind deadline_timer_queue_unit dtq_checker u_dtq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .req_i       (req_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

### tb/deadline_timer_queue_unit_checker.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit_checker
// watches request and result channels, predicts the timer table and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module deadline_timer_queue_unit_checker import dtq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_o,
  input  req_t       req_i,
  input  logic       res_valid_o,
  input  res_t       res_o,
  output int         fail_count,
  output int         pending,
  output int         accepted,
  output int         fired_count
);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  logic [NUM_SLOTS-1:0] armed;
  logic [TIME_W-1:0]    due   [NUM_SLOTS];
  logic [IV_W-1:0]      period[NUM_SLOTS];
  logic [15:0]          tag   [NUM_SLOTS];
  logic [15:0]          seq_next;
  res_t                 expected_results[$];

  assign pending = expected_results.size();

  function automatic logic soonest(output logic [TIME_W-1:0] when);
    logic any;
    any  = 1'b0;
    when = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (armed[i] && (!any || due[i] < when)) begin
        when = due[i];
        any  = 1'b1;
      end
    end
    return any;
  endfunction

  task automatic predict_timer_op(input req_t r);
    res_t                 batch[$];
    res_t                 e;
    logic [TIME_W-1:0]    cur;
    logic [TIME_W:0]      sum;
    logic [NUM_SLOTS-1:0] taken;
    logic                 any;
    int                   slot;
    int                   pick;
    e = '0;
    case (r.func)
      FN_ADD: begin
        slot = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!armed[i]) slot = i;
        if (slot < 0) begin
          e.status = STAT_FULL;
        end else begin
          any = soonest(cur);
          e.status = STAT_OK;
          e.earliest_changed = !any || r.deadline < cur;
          armed[slot]  = 1'b1;
          due[slot]    = r.deadline;
          period[slot] = r.repeat_interval;
          tag[slot]    = seq_next;
          seq_next     = seq_next + 16'd1;
          e.handle_slot = 4'(slot);
          e.handle_seq  = tag[slot];
        end
        batch.push_back(e);
      end
      FN_CANCEL: begin
        e.status = STAT_NOTFOUND;
        if (armed[r.cancel_slot] && tag[r.cancel_slot] == r.cancel_seq) begin
          armed[r.cancel_slot] = 1'b0;
          e.status = STAT_OK;
        end
        batch.push_back(e);
      end
      FN_TICK: begin
        taken = '0;
        forever begin
          pick = -1;
          for (int i = 0; i < NUM_SLOTS; i++)
            if (armed[i] && !taken[i] && due[i] <= r.tick_time &&
                (pick < 0 || due[i] < due[pick])) pick = i;
          if (pick < 0) break;
          taken[pick] = 1'b1;
          e = '0;
          e.status = STAT_OK;
          e.handle_slot = 4'(pick);
          e.handle_seq = tag[pick];
          e.fired = 1'b1;
          batch.push_back(e);
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (taken[i]) begin
            if (period[i] != '0) begin
              sum = {1'b0, r.tick_time} + period[i];
              due[i] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            end else begin
              armed[i] = 1'b0;
            end
          end
        end
        if (batch.size() == 0) begin
          e = '0;
          e.status = STAT_EMPTY;
          batch.push_back(e);
        end
      end
      default: ;
    endcase
    any = soonest(cur);
    foreach (batch[k]) begin
      batch[k].last = (k == batch.size() - 1);
      batch[k].next_valid = any;
      batch[k].next_deadline = cur;
      expected_results.push_back(batch[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      armed = '0;
      seq_next = '0;
      fail_count <= 0;
      accepted <= 0;
      fired_count <= 0;
      expected_results.delete();
    end else begin
      if (res_valid_o) begin
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %p", res_o);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.fired) fired_count <= fired_count + 1;
          if (res_o !== exp_r) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("result wrong: expected %p, got %p", exp_r, res_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        accepted <= accepted + 1;
        predict_timer_op(req_i);
      end
    end
  end

endmodule

### tb/deadline_timer_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit_tb
// directed and random add, cancel and tick traffic with idle gaps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module deadline_timer_queue_unit_tb;
  import dtq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REQ_W = $bits(req_t);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;
  int   fail_count, pending, accepted, fired_count;
  int   stall_cycles = 0;
  logic no_gaps = 1'b0;
  logic [TIME_W-1:0] now_us = '0;
  logic [3:0]  known_slot[$];
  logic [15:0] known_seq[$];

  always #2 clk_i = ~clk_i;

  deadline_timer_queue_unit dut (.*);

  deadline_timer_queue_unit_checker u_checker (.*);

  always @(posedge clk_i) begin
    if (start_i && !busy_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("deadline_timer_queue_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (res_valid_o && res_o.status == STAT_OK && !res_o.fired && known_slot.size() < 40) begin
      known_slot.push_back(res_o.handle_slot);
      known_seq.push_back(res_o.handle_seq);
    end

  task automatic send(input req_t r);
    if (!no_gaps && $urandom_range(99) < 38) begin
      start_i <= 1'b0;
      req_i   <= REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      @(posedge clk_i);
      while (!no_gaps && $urandom_range(99) < 38) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic release_bus();
    start_i <= 1'b0;
    req_i   <= REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    @(posedge clk_i);
  endtask

  function automatic req_t timer_op(input func_e f, input logic [TIME_W-1:0] t,
                                    input logic [IV_W-1:0] iv);
    req_t r;
    r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.func = f;
    r.deadline = t;
    r.tick_time = t;
    r.repeat_interval = iv;
    return r;
  endfunction

  function automatic req_t random_op();
    req_t r;
    int   k;
    k = $urandom_range(99);
    r = timer_op(FN_ADD, now_us + $urandom_range(2000), '0);
    if ($urandom_range(3) != 0) r.repeat_interval = $urandom_range(1500, 1);
    if (k < 3) r.repeat_interval = {$urandom};
    if (k < 40) return r;
    if (k < 60) begin
      r.func = FN_CANCEL;
      if (known_slot.size() != 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(known_slot.size() - 1);
        r.cancel_slot = known_slot[k];
        r.cancel_seq  = known_seq[k];
      end
      return r;
    end
    if (k < 64) begin
      r.func = FN_NONE;
      return r;
    end
    r.func = FN_TICK;
    r.tick_time = now_us + $urandom_range(800);
    if (k > 97) r.tick_time = TIME_W'({$urandom, $urandom});
    return r;
  endfunction

  initial begin
    req_t r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(timer_op(FN_TICK, '0, '0));
    send(timer_op(FN_CANCEL, '0, '0));
    send(timer_op(FN_ADD, TIME_MAX, '0));
    send(timer_op(FN_ADD, '0, {IV_W{1'b1}}));
    send(timer_op(FN_ADD, 63'd5, 32'd0));
    send(timer_op(FN_ADD, 63'd5, 32'd10));
    send(timer_op(FN_ADD, 63'd3, 32'd0));
    for (int i = 0; i < 12; i++) send(timer_op(FN_ADD, 63'd100 + i, 32'd1));
    send(timer_op(FN_NONE, '0, '0));
    send(timer_op(FN_TICK, 63'd10, '0));
    send(timer_op(FN_TICK, TIME_MAX - 63'd2, '0));
    r = timer_op(FN_CANCEL, '0, '0);
    r.cancel_slot = 4'd1;
    r.cancel_seq = 16'd1;
    send(r);
    send(r);
    send(timer_op(FN_TICK, TIME_MAX, '0));
    release_bus();
    wait (pending == 0);
    for (int i = 0; i < 16; i++) begin
      r = timer_op(FN_CANCEL, '0, '0);
      r.cancel_slot = 4'(i);
      r.cancel_seq = 16'hFFFF;
      send(r);
    end
    for (int n = 0; n < 140; n++) begin
      if (n == 60) no_gaps = 1'b1;
      if (n == 100) no_gaps = 1'b0;
      if (n == 120) begin
        release_bus();
        wait (pending == 0);
      end
      r = random_op();
      if (r.func == FN_TICK && r.tick_time > now_us && r.tick_time < TIME_MAX - 63'd10000)
        now_us = r.tick_time;
      send(r);
    end
    release_bus();
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    $display("sent %0d timer operations, %0d timers fired", accepted, fired_count);
    if (fail_count == 0 && pending == 0) begin
      $display("deadline_timer_queue_unit: match");
    end else begin
      $display("deadline_timer_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
